// File: rtl/core/dfws_pkg.sv
// ----------------------------------------------------------------------------
// dfws_pkg: shared types for the depth-filtered weighted select block
// Request and response payload structs and command codes.
// ----------------------------------------------------------------------------
package dfws_pkg;

  localparam int unsigned FIELD_W = 16;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [3:0]                entry_index;
    logic signed [FIELD_W-1:0] entry_low;
    logic signed [FIELD_W-1:0] entry_high;
    logic [FIELD_W-1:0]        entry_weight;
    logic [FIELD_W-1:0]        entry_kind;
    logic signed [FIELD_W-1:0] sample_depth;
    logic [FIELD_W-1:0]        random_fraction;
  } in_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] chosen_kind;
    logic               matched;
  } out_rsp_t;

endpackage

// File: rtl/core/depth_filtered_weighted_select_top.sv
// ----------------------------------------------------------------------------
// depth_filtered_weighted_select_top: roulette selection over a depth table
// Timing: a write request is taken while idle and leaves the sequencer idle; a
//   sample request runs a sum pass, a multiply, a scan pass (skipped when the
//   total weight is 0) and the handoff to the output register before out_valid.
// Flow: one request at a time; a sample holds in_stall high through two passes
//   over the single read port of the entry memory (one entry per cycle each, a
//   read drain after each, N = entry count clamped to MAX_ENTRIES), the multiply
//   and the handoff, which waits while the output register is still held.
// Reset (rst_n, synchronous, active low): entry count 0, sequencer idle, no
//   result pending; table contents are undefined until written.
// ----------------------------------------------------------------------------
module depth_filtered_weighted_select_top #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned RANDOM_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration: entry count
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  dfws_pkg::in_req_t   in_req,
  // response channel
  output logic                out_valid,
  input  logic                out_stall,
  output dfws_pkg::out_rsp_t  out_rsp
);

  // Stored weight and random value keep at most the 16 bits of their fields.
  localparam int unsigned SW     = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int unsigned RW     = (RANDOM_BITS < 16) ? RANDOM_BITS : 16;
  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  // Total weight of up to MAX_ENTRIES entries.
  localparam int unsigned TOT_W  = SW + CNT_W;
  // Both sides of r*T < S*2^RANDOM_BITS fit here.
  localparam int unsigned CMP_W  = TOT_W + RANDOM_BITS;
  localparam int unsigned PROD_W = RW + TOT_W;

  typedef struct packed {
    logic [15:0]   low;
    logic [15:0]   high;
    logic [SW-1:0] weight;
    logic [15:0]   kind;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t             state_r;
  logic [4:0]         entry_count_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   iss_r;
  logic               rv_r;
  logic [15:0]        depth_r;
  logic [RW-1:0]      rand_r;
  logic [TOT_W-1:0]   total_r;
  logic [TOT_W-1:0]   run_r;
  logic [CMP_W-1:0]   prod_r;
  dfws_pkg::out_rsp_t res_r;
  dfws_pkg::out_rsp_t out_rsp_r;
  logic               out_valid_r;

  entry_t             mem [MAX_ENTRIES];
  entry_t             rd_data_r;

  logic               accept;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_entry;
  logic [IDX_W-1:0]   rd_addr;
  logic               issue;
  logic               eligible;
  logic [TOT_W-1:0]   w_ext;
  logic [TOT_W-1:0]   total_nxt;
  logic [TOT_W-1:0]   run_nxt;
  logic [PROD_W-1:0]  prod;
  logic               hit;
  logic               pass_end;
  logic [CNT_W-1:0]   cnt_nxt;

  // --------------------------------------------------------------------------
  // Handshake: take a request only while the sequencer is idle.
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // --------------------------------------------------------------------------
  // Table write: drop writes aimed past the end of the table.
  // --------------------------------------------------------------------------
  assign mem_we  = accept && (in_req.command == dfws_pkg::CMD_WRITE) &&
                   (32'(in_req.entry_index) < 32'(MAX_ENTRIES));
  assign wr_addr = IDX_W'(in_req.entry_index);

  always_comb begin
    wr_entry.low    = in_req.entry_low;
    wr_entry.high   = in_req.entry_high;
    wr_entry.weight = in_req.entry_weight[SW-1:0];
    wr_entry.kind   = in_req.entry_kind;
  end

  // Clamp an oversized entry count to the table depth.
  always_comb begin
    if (32'(entry_count_r) > 32'(MAX_ENTRIES)) begin
      cnt_nxt = CNT_W'(MAX_ENTRIES);
    end else begin
      cnt_nxt = CNT_W'(entry_count_r);
    end
  end

  // --------------------------------------------------------------------------
  // Read stream: one entry per cycle, data back in the next cycle (rv_r).
  // --------------------------------------------------------------------------
  assign issue    = ((state_r == S_SUM) || (state_r == S_SCAN)) && (iss_r < cnt_r);
  assign rd_addr  = iss_r[IDX_W-1:0];
  assign pass_end = !issue && !rv_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Entry qualifies when its window holds the depth (empty windows never do).
  assign eligible  = rv_r &&
                     ($signed(depth_r) >= $signed(rd_data_r.low)) &&
                     ($signed(depth_r) <= $signed(rd_data_r.high));
  assign w_ext     = eligible ? TOT_W'(rd_data_r.weight) : '0;
  assign total_nxt = total_r + w_ext;
  assign run_nxt   = run_r + w_ext;

  // r * T, registered before the scan pass uses it.
  assign prod = rand_r * total_r;

  // Exact form of fraction < S / T.
  assign hit = eligible && (prod_r < (CMP_W'(run_nxt) << RANDOM_BITS));

  // --------------------------------------------------------------------------
  // Sequencer: sum pass, multiply, scan pass (skipped on zero total), then hand off the result.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
      rv_r          <= 1'b0;
      iss_r         <= '0;
      cnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end

      // Retire the held response once the far side takes it, unless a new
      // one moves in at the same edge.
      if (out_valid_r && !out_stall && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end

      rv_r <= issue;
      if (issue) begin
        iss_r <= iss_r + CNT_W'(1);
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_req.command == dfws_pkg::CMD_SAMPLE)) begin
            cnt_r   <= cnt_nxt;
            iss_r   <= '0;
            depth_r <= in_req.sample_depth;
            rand_r  <= in_req.random_fraction[RW-1:0];
            total_r <= '0;
            run_r   <= '0;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          total_r <= total_nxt;
          if (pass_end) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= CMP_W'(prod);
          iss_r  <= '0;
          if (total_r == '0) begin
            res_r   <= '0;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          run_r <= run_nxt;
          if (hit) begin
            res_r.chosen_kind <= rd_data_r.kind;
            res_r.matched     <= 1'b1;
            state_r           <= S_RESULT;
          end else if (pass_end) begin
            res_r   <= '0;
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          // Hold until the output register is free.
          if (!out_valid_r || !out_stall) begin
            out_rsp_r   <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_scan_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (total_r != '0))
    else $error("scan pass started with zero total weight");

  a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SUM) || (state_r == S_SCAN)) |-> (iss_r <= cnt_r))
    else $error("read pointer ran past entry count");

  a_scan_always_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !(pass_end && !hit))
    else $error("scan pass ended without a selection despite nonzero total");

  a_sample_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.command == dfws_pkg::CMD_SAMPLE)) |=> (state_r == S_SUM))
    else $error("sample request did not start the sum pass");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.command == dfws_pkg::CMD_WRITE)) |=> (state_r == S_IDLE))
    else $error("write request left the sequencer busy");

endmodule
